### rtl/core/chorus_pkg.sv
// Shared types and constants for the stereo three-LFO chorus.
`timescale 1ns / 1ps
package chorus_pkg;

   localparam int SMP_W = 24;
   localparam int MIX_W = 17;
   localparam int TYPE_W = 2;
   localparam int CSR_IDX_W = 2;

   localparam int DELAY_LENGTH_DEF = 2048;
   localparam int SAMPLE_RATE_DEF = 48000;
   localparam int SINE_TABLE_SIZE_DEF = 1024;

   localparam logic [CSR_IDX_W-1:0] CSR_IDX_TYPE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_MIX = 2'd1;

   localparam logic [TYPE_W-1:0] TYPE_SUBTLE = 2'd0;
   localparam logic [TYPE_W-1:0] TYPE_DEEP = 2'd2;
   localparam logic [MIX_W-1:0] MIX_RESET = 17'd32768;
   localparam logic [MIX_W-1:0] MIX_FULL = 17'd65536;

   localparam logic [31:0] PHASE1_RESET = 32'h0000_0000;
   localparam logic [31:0] PHASE2_RESET = 32'h547A_E148;
   localparam logic [31:0] PHASE3_RESET = 32'hA8F5_C28F;

   // Odd polynomial coefficients for sine over a quarter cycle, Q30.
   localparam logic [31:0] SC1 = 32'd1686629713;
   localparam logic [31:0] SC3 = 32'd693598669;
   localparam logic [31:0] SC5 = 32'd85569306;
   localparam logic [31:0] SC7 = 32'd5026995;
   localparam logic [31:0] SC9 = 32'd172272;

   // Half of the stereo spread per preset, Q16.
   localparam logic [MIX_W-1:0] SPREAD_K [3] = '{17'd9830, 17'd16384, 17'd26214};

   typedef struct packed {
      logic signed [SMP_W-1:0] left;
      logic signed [SMP_W-1:0] right;
   } sample_pair_type;

   typedef struct packed {
      logic [TYPE_W-1:0] chorus_type;
      logic [MIX_W-1:0]  wet_dry_mix;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WRITE,
      ST_SIN_X,
      ST_SIN_X2,
      ST_SIN_H,
      ST_SIN_V,
      ST_TAP_D,
      ST_TAP_P,
      ST_TAP_A,
      ST_TAP_B,
      ST_BLEND,
      ST_DONE
   } back_state_type;

endpackage

### rtl/core/chorus_fifo.sv
// Two-entry queue used between the chorus stages and on the result side.
`timescale 1ns / 1ps
module chorus_fifo #(
   parameter int WIDTH = 48
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   output logic             is_full,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             is_empty
);
   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             do_wr, do_rd;

   assign is_full = (cnt_ff == 2'd2);
   assign is_empty = (cnt_ff == 2'd0);
   assign do_wr = wr_en & ~is_full;
   assign do_rd = rd_en & ~is_empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_wr ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_rd ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in = cnt_ff;
      if (do_wr && !do_rd) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (do_rd && !do_wr) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end
endmodule

### rtl/core/chorus_front.sv
// Front end: register port, sample intake and mono handling.
`timescale 1ns / 1ps
module chorus_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  push,
   output logic                                  full,
   input  logic signed [chorus_pkg::SMP_W-1:0]   req_left_in,
   input  logic signed [chorus_pkg::SMP_W-1:0]   req_right_in,
   input  logic                                  req_single_channel,
   input  logic                                  valid,
   output logic                                  ready,
   input  logic [chorus_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [chorus_pkg::MIX_W-1:0]          csr_data,
   input  logic                                  q_full,
   input  logic                                  clearing,
   output logic                                  q_push,
   output chorus_pkg::sample_pair_type           q_data,
   output chorus_pkg::cfg_type                   cfg
);
   import chorus_pkg::*;

   logic [TYPE_W-1:0] type_ff, type_in;
   logic [MIX_W-1:0]  mix_ff, mix_in;
   logic              wr;

   assign ready = 1'b1;
   assign wr = valid & ready;
   assign full = q_full | clearing;
   assign q_push = push & ~full;
   assign q_data.left = req_left_in;
   assign q_data.right = req_single_channel ? req_left_in : req_right_in;
   assign cfg.chorus_type = type_ff;
   assign cfg.wet_dry_mix = mix_ff;

   always_comb begin
      type_in = type_ff;
      mix_in = mix_ff;
      if (wr) begin
         case (csr_index)
            CSR_IDX_TYPE: type_in = (csr_data[TYPE_W-1:0] > TYPE_DEEP) ? TYPE_DEEP
                                                                     : csr_data[TYPE_W-1:0];
            CSR_IDX_MIX:  mix_in = csr_data;
            default:      ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         type_ff <= TYPE_SUBTLE;
         mix_ff <= MIX_RESET;
      end else begin
         type_ff <= type_in;
         mix_ff <= mix_in;
      end
   end
endmodule

### rtl/core/chorus_back.sv
// Back end: delay lines, LFO sines, interpolated taps and the output blend.
`timescale 1ns / 1ps
module chorus_back #(
   parameter int DELAY_LENGTH = chorus_pkg::DELAY_LENGTH_DEF,
   parameter int SAMPLE_RATE = chorus_pkg::SAMPLE_RATE_DEF,
   parameter int SINE_TABLE_SIZE = chorus_pkg::SINE_TABLE_SIZE_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  chorus_pkg::cfg_type         cfg,
   input  logic                        in_valid,
   input  chorus_pkg::sample_pair_type in_data,
   output logic                        in_pop,
   input  logic                        out_full,
   output logic                        out_push,
   output chorus_pkg::sample_pair_type out_data,
   output logic                        clearing
);
   import chorus_pkg::*;

   localparam int AW = $clog2(DELAY_LENGTH);
   localparam int PW = AW + 17;
   localparam int TB = $clog2(SINE_TABLE_SIZE);
   localparam logic [PW-1:0] LINE_Q16 = PW'(64'(DELAY_LENGTH) << 16);
   localparam logic [AW-1:0] LAST_POS = AW'(DELAY_LENGTH - 1);
   localparam logic [31:0] PHASE_MASK = ~((32'd1 << (32 - TB)) - 32'd1);
   localparam logic [63:0] SR = 64'(SAMPLE_RATE);
   localparam logic [63:0] TWO32 = 64'd4294967296;

   localparam logic [31:0] INC1 [3] = '{
      32'((64'd50 * TWO32 + 64'd50 * SR) / (64'd100 * SR)),
      32'((64'd80 * TWO32 + 64'd50 * SR) / (64'd100 * SR)),
      32'((64'd30 * TWO32 + 64'd50 * SR) / (64'd100 * SR))};
   localparam logic [31:0] INC2 [3] = '{
      32'((64'd55 * TWO32 + 64'd50 * SR) / (64'd100 * SR)),
      32'((64'd88 * TWO32 + 64'd50 * SR) / (64'd100 * SR)),
      32'((64'd33 * TWO32 + 64'd50 * SR) / (64'd100 * SR))};
   localparam logic [31:0] INC3 [3] = '{
      32'((64'd45 * TWO32 + 64'd50 * SR) / (64'd100 * SR)),
      32'((64'd72 * TWO32 + 64'd50 * SR) / (64'd100 * SR)),
      32'((64'd27 * TWO32 + 64'd50 * SR) / (64'd100 * SR))};
   localparam logic [31:0] BASE [3] = '{
      32'((64'd7 * SR * 64'd65536 + 64'd500) / 64'd1000),
      32'((64'd10 * SR * 64'd65536 + 64'd500) / 64'd1000),
      32'((64'd15 * SR * 64'd65536 + 64'd500) / 64'd1000)};
   localparam logic [31:0] DEP [3] = '{
      32'((64'd2 * SR * 64'd65536 + 64'd500) / 64'd1000),
      32'((64'd4 * SR * 64'd65536 + 64'd500) / 64'd1000),
      32'((64'd8 * SR * 64'd65536 + 64'd500) / 64'd1000)};
   localparam logic [31:0] DEP7 [3] = '{
      32'((64'd14 * SR * 64'd65536 + 64'd5000) / 64'd10000),
      32'((64'd28 * SR * 64'd65536 + 64'd5000) / 64'd10000),
      32'((64'd56 * SR * 64'd65536 + 64'd5000) / 64'd10000)};

   back_state_type state_ff, state_in;

   logic signed [SMP_W-1:0] mem_l [DELAY_LENGTH];
   logic signed [SMP_W-1:0] mem_r [DELAY_LENGTH];
   logic signed [SMP_W-1:0] rd_l_ff, rd_r_ff;
   logic                    mem_we;
   logic [AW-1:0]           mem_waddr, mem_raddr;
   logic signed [SMP_W-1:0] mem_wdata_l, mem_wdata_r;

   logic [AW-1:0]           clr_ff, clr_in;
   logic [AW-1:0]           wp_ff, wp_in;
   logic [31:0]             ph_ff [3];
   logic [31:0]             ph_in [3];
   logic signed [SMP_W-1:0] dry_l_ff, dry_l_in, dry_r_ff, dry_r_in;
   logic [30:0]             x_ff, x_in, x2_ff, x2_in;
   logic [1:0]              quad_ff, quad_in;
   logic [31:0]             p_ff, p_in;
   logic [1:0]              hcnt_ff, hcnt_in;
   logic [1:0]              lfo_ff, lfo_in;
   logic signed [15:0]      s_ff [3];
   logic signed [15:0]      s_in [3];
   logic [1:0]              tap_ff, tap_in;
   logic [PW-1:0]           delay_ff, delay_in;
   logic [15:0]             frac_ff, frac_in;
   logic [AW-1:0]           nxt_ff, nxt_in;
   logic signed [SMP_W-1:0] a_ff, a_in;
   logic signed [SMP_W:0]   acc_ff, acc_in;
   logic signed [SMP_W-1:0] wet_l_ff, wet_l_in, wet_r_ff, wet_r_in;
   logic [2:0]              bcnt_ff, bcnt_in;
   logic signed [42:0]      bacc_ff, bacc_in;
   logic signed [SMP_W-1:0] sp_l_ff, sp_l_in, sp_r_ff, sp_r_in;
   logic signed [SMP_W-1:0] out_l_ff, out_l_in, out_r_ff, out_r_in;

   // Shared datapath signals.
   logic [TYPE_W-1:0] t_sel;
   logic [MIX_W-1:0]  mix_eff;
   logic [31:0]       mul_a, mul_b;
   logic [63:0]       umul;
   logic signed [24:0] smul_a;
   logic signed [17:0] smul_b;
   logic signed [42:0] sprod;
   logic [31:0]       phase_sel, q_phase, h_coef, dep_sel, delay32;
   logic [32:0]       v_raw;
   logic [17:0]       v_rnd;
   logic [15:0]       v_cl;
   logic signed [15:0] s_tap;
   logic [15:0]       s_off;
   logic [PW-1:0]     d_mod, pos_raw, pos;
   logic [AW-1:0]     idx;
   logic signed [SMP_W-1:0] rd_sel;
   logic signed [24:0] diff;
   logic signed [25:0] tv, avg_sum;
   logic signed [SMP_W-1:0] bx, by;
   logic [MIX_W-1:0]  bw;
   logic signed [43:0] bsum;
   logic signed [27:0] bres;
   logic signed [SMP_W-1:0] bsat;
   logic              start;

   assign t_sel = cfg.chorus_type;
   assign mix_eff = (cfg.wet_dry_mix > MIX_FULL) ? MIX_FULL : cfg.wet_dry_mix;
   assign start = (state_ff == ST_IDLE) && in_valid && !out_full;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:  state_in = (clr_ff == LAST_POS) ? ST_IDLE : ST_CLEAR;
         ST_IDLE:   state_in = start ? ST_WRITE : ST_IDLE;
         ST_WRITE:  state_in = ST_SIN_X;
         ST_SIN_X:  state_in = ST_SIN_X2;
         ST_SIN_X2: state_in = ST_SIN_H;
         ST_SIN_H:  state_in = (hcnt_ff == 2'd3) ? ST_SIN_V : ST_SIN_H;
         ST_SIN_V:  state_in = (lfo_ff == 2'd2) ? ST_TAP_D : ST_SIN_X;
         ST_TAP_D:  state_in = ST_TAP_P;
         ST_TAP_P:  state_in = ST_TAP_A;
         ST_TAP_A:  state_in = ST_TAP_B;
         ST_TAP_B:  state_in = (tap_ff == 2'd3) ? ST_BLEND : ST_TAP_D;
         ST_BLEND:  state_in = (bcnt_ff == 3'd7) ? ST_DONE : ST_BLEND;
         ST_DONE:   state_in = ST_IDLE;
         default:   state_in = ST_CLEAR;
      endcase
   end

   // Control outputs.
   always_comb begin
      in_pop = 1'b0;
      out_push = 1'b0;
      mem_we = 1'b0;
      mem_waddr = wp_ff;
      mem_wdata_l = dry_l_ff;
      mem_wdata_r = dry_r_ff;
      mem_raddr = nxt_ff;
      clearing = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            clearing = 1'b1;
            mem_we = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata_l = '0;
            mem_wdata_r = '0;
         end
         ST_IDLE:  in_pop = start;
         ST_WRITE: mem_we = 1'b1;
         ST_TAP_P: mem_raddr = idx;
         ST_DONE:  out_push = 1'b1;
         default:  ;
      endcase
   end

   // Multiplier operand selection.
   always_comb begin
      case (lfo_ff)
         2'd0:    phase_sel = ph_ff[0];
         2'd1:    phase_sel = ph_ff[1];
         default: phase_sel = ph_ff[2];
      endcase
      case (hcnt_ff)
         2'd0:    h_coef = SC7;
         2'd1:    h_coef = SC5;
         2'd2:    h_coef = SC3;
         default: h_coef = SC1;
      endcase
      case (tap_ff)
         2'd0:    s_tap = s_ff[0];
         2'd3:    s_tap = s_ff[2];
         default: s_tap = s_ff[1];
      endcase
      s_off = {~s_tap[15], s_tap[14:0]};
      dep_sel = tap_ff[0] ? DEP7[t_sel] : DEP[t_sel];
      mul_a = 32'({1'b0, x_ff});
      mul_b = 32'({1'b0, x_ff});
      case (state_ff)
         ST_SIN_H: begin
            mul_a = 32'({1'b0, x2_ff});
            mul_b = p_ff;
         end
         ST_SIN_V: mul_b = p_ff;
         ST_TAP_D: begin
            mul_a = 32'(s_off);
            mul_b = dep_sel;
         end
         default: ;
      endcase
   end

   assign umul = 64'(mul_a) * 64'(mul_b);
   assign q_phase = phase_sel & PHASE_MASK;
   assign v_raw = umul[62:30];
   assign v_rnd = v_raw[32:15] + 18'(v_raw[14]);
   assign v_cl = (v_rnd > 18'd32767) ? 16'd32767 : v_rnd[15:0];
   assign delay32 = BASE[t_sel] - dep_sel + umul[46:15];

   // Read position: the delay can exceed the line once, and so can the sum.
   assign d_mod = (delay_ff >= LINE_Q16) ? delay_ff - LINE_Q16 : delay_ff;
   assign pos_raw = PW'({wp_ff, 16'd0}) + LINE_Q16 - d_mod;
   assign pos = (pos_raw >= LINE_Q16) ? pos_raw - LINE_Q16 : pos_raw;
   assign idx = pos[16 +: AW];

   assign rd_sel = tap_ff[1] ? rd_r_ff : rd_l_ff;
   assign diff = 25'(rd_sel) - 25'(a_ff);

   always_comb begin
      case (bcnt_ff[2:1])
         2'd0: begin
            bx = wet_l_ff;
            by = wet_r_ff;
            bw = SPREAD_K[t_sel];
         end
         2'd1: begin
            bx = wet_r_ff;
            by = wet_l_ff;
            bw = SPREAD_K[t_sel];
         end
         2'd2: begin
            bx = dry_l_ff;
            by = sp_l_ff;
            bw = mix_eff;
         end
         default: begin
            bx = dry_r_ff;
            by = sp_r_ff;
            bw = mix_eff;
         end
      endcase
      if (state_ff == ST_BLEND) begin
         smul_a = bcnt_ff[0] ? 25'(by) : 25'(bx);
         smul_b = bcnt_ff[0] ? $signed({1'b0, bw}) : $signed(18'd65536 - {1'b0, bw});
      end else begin
         smul_a = diff;
         smul_b = $signed({2'b00, frac_ff});
      end
   end

   assign sprod = smul_a * smul_b;
   assign tv = 26'(a_ff) + sprod[41:16];
   assign avg_sum = 26'(acc_ff) + tv;
   assign bsum = 44'(bacc_ff) + 44'(sprod);
   assign bres = bsum[43:16];
   assign bsat = (bres > 28'sd8388607) ? 24'sh7FFFFF :
                 (bres < -28'sd8388608) ? 24'sh800000 : bres[23:0];

   // Datapath next values.
   always_comb begin
      clr_in = clr_ff;
      wp_in = wp_ff;
      ph_in = ph_ff;
      dry_l_in = dry_l_ff;
      dry_r_in = dry_r_ff;
      x_in = x_ff;
      x2_in = x2_ff;
      quad_in = quad_ff;
      p_in = p_ff;
      hcnt_in = hcnt_ff;
      lfo_in = lfo_ff;
      s_in = s_ff;
      tap_in = tap_ff;
      delay_in = delay_ff;
      frac_in = frac_ff;
      nxt_in = nxt_ff;
      a_in = a_ff;
      acc_in = acc_ff;
      wet_l_in = wet_l_ff;
      wet_r_in = wet_r_ff;
      bcnt_in = bcnt_ff;
      bacc_in = bacc_ff;
      sp_l_in = sp_l_ff;
      sp_r_in = sp_r_ff;
      out_l_in = out_l_ff;
      out_r_in = out_r_ff;
      case (state_ff)
         ST_CLEAR: clr_in = clr_ff + AW'(1);
         ST_IDLE: begin
            dry_l_in = in_data.left;
            dry_r_in = in_data.right;
            lfo_in = 2'd0;
         end
         ST_SIN_X: begin
            quad_in = q_phase[31:30];
            x_in = q_phase[30] ? 31'h4000_0000 - 31'(q_phase[29:0])
                               : 31'(q_phase[29:0]);
         end
         ST_SIN_X2: begin
            x2_in = umul[60:30];
            p_in = SC9;
            hcnt_in = 2'd0;
         end
         ST_SIN_H: begin
            p_in = h_coef - umul[61:30];
            hcnt_in = hcnt_ff + 2'd1;
         end
         ST_SIN_V: begin
            s_in[lfo_ff] = quad_ff[1] ? -$signed(v_cl) : $signed(v_cl);
            lfo_in = lfo_ff + 2'd1;
            tap_in = 2'd0;
         end
         ST_TAP_D: delay_in = delay32[PW-1:0];
         ST_TAP_P: begin
            frac_in = pos[15:0];
            nxt_in = (idx == LAST_POS) ? '0 : idx + AW'(1);
         end
         ST_TAP_A: a_in = rd_sel;
         ST_TAP_B: begin
            if (!tap_ff[0]) begin
               acc_in = tv[SMP_W:0];
            end else if (!tap_ff[1]) begin
               wet_l_in = avg_sum[SMP_W:1];
            end else begin
               wet_r_in = avg_sum[SMP_W:1];
            end
            tap_in = tap_ff + 2'd1;
            bcnt_in = 3'd0;
         end
         ST_BLEND: begin
            if (!bcnt_ff[0]) begin
               bacc_in = sprod;
            end else begin
               case (bcnt_ff[2:1])
                  2'd0:    sp_l_in = bsat;
                  2'd1:    sp_r_in = bsat;
                  2'd2:    out_l_in = bsat;
                  default: out_r_in = bsat;
               endcase
            end
            bcnt_in = bcnt_ff + 3'd1;
         end
         ST_DONE: begin
            ph_in[0] = ph_ff[0] + INC1[t_sel];
            ph_in[1] = ph_ff[1] + INC2[t_sel];
            ph_in[2] = ph_ff[2] + INC3[t_sel];
            wp_in = (wp_ff == LAST_POS) ? '0 : wp_ff + AW'(1);
         end
         default: ;
      endcase
   end

   assign out_data.left = out_l_ff;
   assign out_data.right = out_r_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         wp_ff <= '0;
         ph_ff[0] <= PHASE1_RESET;
         ph_ff[1] <= PHASE2_RESET;
         ph_ff[2] <= PHASE3_RESET;
         hcnt_ff <= 2'd0;
         lfo_ff <= 2'd0;
         tap_ff <= 2'd0;
         bcnt_ff <= 3'd0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         wp_ff <= wp_in;
         ph_ff <= ph_in;
         hcnt_ff <= hcnt_in;
         lfo_ff <= lfo_in;
         tap_ff <= tap_in;
         bcnt_ff <= bcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dry_l_ff <= dry_l_in;
      dry_r_ff <= dry_r_in;
      x_ff <= x_in;
      x2_ff <= x2_in;
      quad_ff <= quad_in;
      p_ff <= p_in;
      s_ff <= s_in;
      delay_ff <= delay_in;
      frac_ff <= frac_in;
      nxt_ff <= nxt_in;
      a_ff <= a_in;
      acc_ff <= acc_in;
      wet_l_ff <= wet_l_in;
      wet_r_ff <= wet_r_in;
      bacc_ff <= bacc_in;
      sp_l_ff <= sp_l_in;
      sp_r_ff <= sp_r_in;
      out_l_ff <= out_l_in;
      out_r_ff <= out_r_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_l[mem_waddr] <= mem_wdata_l;
         mem_r[mem_waddr] <= mem_wdata_r;
      end
      rd_l_ff <= mem_l[mem_raddr];
      rd_r_ff <= mem_r[mem_raddr];
   end
endmodule

### rtl/core/stereo_three_lfo_chorus_top.sv
// Stereo chorus: three sine LFOs modulate interpolated taps on two delay lines.
// A pushed pair passes the work queue, the back end and the result queue before it shows.
// The sequential back end takes the next sample pair only when idle with room in the result
// queue, after three 7-step sine evaluations, four taps on one read port and 8 blend steps.
// Reset: synchronous; afterwards a clearing pass zeroes every entry of both delay
// lines while full stays high; register writes are taken throughout.
`timescale 1ns / 1ps
module stereo_three_lfo_chorus_top #(
   parameter int DELAY_LENGTH = chorus_pkg::DELAY_LENGTH_DEF,
   parameter int SAMPLE_RATE = chorus_pkg::SAMPLE_RATE_DEF,
   parameter int SINE_TABLE_SIZE = chorus_pkg::SINE_TABLE_SIZE_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   output logic                                full,
   input  logic signed [chorus_pkg::SMP_W-1:0] req_left_in,
   input  logic signed [chorus_pkg::SMP_W-1:0] req_right_in,
   input  logic                                req_single_channel,
   output logic                                empty,
   input  logic                                pop,
   output logic signed [chorus_pkg::SMP_W-1:0] rsp_left_out,
   output logic signed [chorus_pkg::SMP_W-1:0] rsp_right_out,
   input  logic                                valid,
   output logic                                ready,
   input  logic [chorus_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [chorus_pkg::MIX_W-1:0]        csr_data
);
   import chorus_pkg::*;

   localparam int PAIR_W = $bits(sample_pair_type);

   sample_pair_type q_wdata, q_rdata, r_wdata, r_rdata;
   cfg_type         cfg;
   logic            q_push, q_full, q_empty, q_pop;
   logic            r_push, r_full;
   logic            clearing;

   chorus_front u_front (
      .clock              (clock),
      .reset              (reset),
      .push               (push),
      .full               (full),
      .req_left_in        (req_left_in),
      .req_right_in       (req_right_in),
      .req_single_channel (req_single_channel),
      .valid              (valid),
      .ready              (ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .q_full             (q_full),
      .clearing           (clearing),
      .q_push             (q_push),
      .q_data             (q_wdata),
      .cfg                (cfg)
   );

   chorus_fifo #(.WIDTH(PAIR_W)) u_work_q (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (q_push),
      .wr_data  (q_wdata),
      .is_full  (q_full),
      .rd_en    (q_pop),
      .rd_data  (q_rdata),
      .is_empty (q_empty)
   );

   chorus_back #(
      .DELAY_LENGTH    (DELAY_LENGTH),
      .SAMPLE_RATE     (SAMPLE_RATE),
      .SINE_TABLE_SIZE (SINE_TABLE_SIZE)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .in_valid (~q_empty),
      .in_data  (q_rdata),
      .in_pop   (q_pop),
      .out_full (r_full),
      .out_push (r_push),
      .out_data (r_wdata),
      .clearing (clearing)
   );

   chorus_fifo #(.WIDTH(PAIR_W)) u_rsp_q (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (r_push),
      .wr_data  (r_wdata),
      .is_full  (r_full),
      .rd_en    (pop),
      .rd_data  (r_rdata),
      .is_empty (empty)
   );

   assign rsp_left_out = r_rdata.left;
   assign rsp_right_out = r_rdata.right;
endmodule
